// ----- src/header_sum_checksum_deframer_macros.svh -----
// Assertion macros for the header/length/sum deframer checker.
// No dependencies; included by the checker file.
`ifndef HEADER_SUM_CHECKSUM_DEFRAMER_MACROS_SVH
`define HEADER_SUM_CHECKSUM_DEFRAMER_MACROS_SVH

// Clocked assertion, disabled during reset.
`define HSCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HSCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/hscd_pkg.sv -----
// Shared types and constants for the header/length/sum deframer.
// No dependencies.
package hscd_pkg;

  typedef enum logic [1:0] {
    EV_IDLE = 2'd0,
    EV_BYTE = 2'd1,
    EV_GOOD = 2'd2,
    EV_DROP = 2'd3
  } event_t;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] MIN_LEN  = 8'd5;
  localparam logic [7:0] LEN_POS  = 8'd2;
  localparam logic [7:0] INST_POS = 8'd3;
  localparam logic [7:0] LAST_MIN = 8'd4;

  typedef struct packed {
    event_t     ev;
    logic [7:0] position;
    logic [7:0] instruction;
  } step_res_t;

endpackage

// ----- src/hscd_parser.sv -----
// Frame parser state and per-word step logic.
// Depends on hscd_pkg.
module hscd_parser #(
  parameter int MAX_FRAME = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            rx_byte,
  output hscd_pkg::step_res_t   res
);

  localparam logic [7:0] MaxFrameB = 8'(MAX_FRAME);

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] inst_r, inst_nxt;
  logic [7:0] next_pos;

  assign next_pos = pos_r + 8'd1;

  always_comb begin
    pos_nxt         = pos_r;
    len_nxt         = len_r;
    sum_nxt         = sum_r;
    inst_nxt        = inst_r;
    res.ev          = hscd_pkg::EV_IDLE;
    res.position    = pos_r;
    res.instruction = 8'd0;
    if (pos_r == 8'd0) begin
      if (rx_byte == hscd_pkg::HDR_BYTE) pos_nxt = 8'd1;
    end else if (pos_r == 8'd1) begin
      pos_nxt = (rx_byte == hscd_pkg::HDR_BYTE) ? hscd_pkg::LEN_POS : 8'd0;
    end else if (pos_r >= MaxFrameB) begin
      // overrun: drop and restart hunt
      pos_nxt  = 8'd0;
      len_nxt  = 8'd0;
      sum_nxt  = 8'd0;
      inst_nxt = 8'd0;
      res.ev   = hscd_pkg::EV_DROP;
    end else begin
      pos_nxt = next_pos;
      res.ev  = hscd_pkg::EV_BYTE;
      if (pos_r == hscd_pkg::LEN_POS) begin
        if (rx_byte < hscd_pkg::MIN_LEN || rx_byte > MaxFrameB) begin
          pos_nxt  = 8'd0;
          len_nxt  = 8'd0;
          sum_nxt  = 8'd0;
          inst_nxt = 8'd0;
          res.ev   = hscd_pkg::EV_DROP;
        end else begin
          len_nxt = rx_byte;
          sum_nxt = rx_byte;
        end
      end else if (pos_r >= hscd_pkg::LAST_MIN && next_pos == len_r) begin
        // last word carries the checksum
        if (rx_byte == sum_r) begin
          res.ev          = hscd_pkg::EV_GOOD;
          res.instruction = inst_r;
        end else begin
          res.ev = hscd_pkg::EV_DROP;
        end
        pos_nxt  = 8'd0;
        len_nxt  = 8'd0;
        sum_nxt  = 8'd0;
        inst_nxt = 8'd0;
      end else begin
        if (pos_r == hscd_pkg::INST_POS) inst_nxt = rx_byte;
        sum_nxt = sum_r + rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 8'd0;
      len_r  <= 8'd0;
      sum_r  <= 8'd0;
      inst_r <= 8'd0;
    end else if (step_en) begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
      inst_r <= inst_nxt;
    end
  end

endmodule

// ----- src/header_sum_checksum_deframer.sv -----
// Header/length/sum-checksum deframer: takes one received byte per word and
// returns one result word per byte, classifying it as header hunt, frame byte,
// good frame end (with the instruction byte) or discard. Throughput is one word
// per clock while out_ready does not stall the result register; an accepted
// word passes the input register, then the single parser step, and out_valid
// rises when it lands in the result register. The frame state advances when a
// word moves from the input register to the result register, so stalls on
// out_ready hold the parser in place.
// Depends on hscd_pkg and hscd_parser.
module header_sum_checksum_deframer #(
  parameter int MAX_FRAME = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_res,
  output logic [7:0] out_echo_byte,
  output logic [7:0] out_position,
  output logic [7:0] out_instruction
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [7:0]          s1_byte_r;
  logic                out_valid_r, out_valid_nxt;
  hscd_pkg::event_t    out_ev_r;
  logic [7:0]          out_echo_r;
  logic [7:0]          out_pos_r;
  logic [7:0]          out_inst_r;
  logic                in_fire;
  logic                adv;
  hscd_pkg::step_res_t step_res;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  hscd_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .rx_byte (s1_byte_r),
    .res     (step_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)  s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (adv)            out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_byte_r <= in_rx_byte;
    if (adv) begin
      out_ev_r   <= step_res.ev;
      out_echo_r <= s1_byte_r;
      out_pos_r  <= step_res.position;
      out_inst_r <= step_res.instruction;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_ev_r;
  assign out_echo_byte   = out_echo_r;
  assign out_position    = out_pos_r;
  assign out_instruction = out_inst_r;

endmodule

// ----- src/hscd_checker.sv -----
// Port-level checks for header_sum_checksum_deframer, bound to the top level.
// Depends on hscd_pkg and header_sum_checksum_deframer_macros.svh.
`include "header_sum_checksum_deframer_macros.svh"

module hscd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_res,
  input logic [7:0] out_echo_byte,
  input logic [7:0] out_position,
  input logic [7:0] out_instruction
);

  `HSCD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped")
  `HSCD_ASSERT(a_in_hold,
    in_valid && !in_ready |=> in_valid && $stable(in_rx_byte), "input word changed")
  `HSCD_ASSERT(a_inst_zero,
    out_valid && out_event_res != hscd_pkg::EV_GOOD |-> out_instruction == 8'd0,
    "instruction set off frame end")
  `HSCD_ASSERT(a_good_pos,
    out_valid && out_event_res == hscd_pkg::EV_GOOD |-> out_position >= 8'd4,
    "frame end too early")
  `HSCD_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind header_sum_checksum_deframer hscd_checker u_hscd_checker (.*);
